// ----- rtl/pscv_pkg.sv -----
// Package for the PCM sample format converter.
// Holds the register index codes and the byte order and width helpers.
// Depends on nothing.
package pscv_pkg;

    typedef enum logic [2:0] {
        REG_IN_BYTES       = 3'd0,
        REG_IN_SIGNED      = 3'd1,
        REG_IN_BIG_ENDIAN  = 3'd2,
        REG_IN_FLOAT       = 3'd3,
        REG_OUT_BYTES      = 3'd4,
        REG_OUT_SIGNED     = 3'd5,
        REG_OUT_BIG_ENDIAN = 3'd6,
        REG_OUT_FLOAT      = 3'd7
    } reg_idx_t;

    localparam logic [7:0] EXP_BIAS_INT = 8'd150;

    // byte count minus one, 0 acts as 1 and 5 to 7 as 4
    function automatic logic [1:0] bytes_code(input logic [2:0] b);
        logic [1:0] c;
        case (b)
            3'd0, 3'd1: c = 2'd0;
            3'd2:       c = 2'd1;
            3'd3:       c = 2'd2;
            default:    c = 2'd3;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [1:0] c);
        logic [31:0] m;
        case (c)
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            2'd2:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] rev_bytes(input logic [31:0] v, input logic [1:0] c);
        logic [31:0] r;
        case (c)
            2'd0:    r = {24'd0, v[7:0]};
            2'd1:    r = {16'd0, v[7:0], v[15:8]};
            2'd2:    r = {8'd0, v[7:0], v[15:8], v[23:16]};
            default: r = {v[7:0], v[15:8], v[23:16], v[31:24]};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sign_bit(input logic [1:0] c);
        return 32'h1 << {c, 3'b111};
    endfunction

    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd31;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/pcm_sample_format_converter.sv -----
// PCM sample format converter top level: four register stages.
// Depends on pscv_pkg.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     sample_in
//  out       output     out_valid / out_stall   sample_out, clipped
//  cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item a cycle while no stall is held; out_valid rises once the item has
// passed the s1, s2, s3 and output registers of the four-stage pipeline: decode
// and multiply, round or count leading zeros, integer round or normalize, byte order.
// Reset clears the valid bits and loads the register reset values.
// A stall held on a full output register freezes every stage.
module pcm_sample_format_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_out,
    output logic        clipped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  pscv_pkg::reg_idx_t cfg_index,
    input  logic [2:0]  cfg_data
);
    import pscv_pkg::*;

    logic [2:0] in_bytes_reg, out_bytes_reg;
    logic in_signed_reg, in_big_endian_reg, in_float_reg;
    logic out_signed_reg, out_big_endian_reg, out_float_reg;

    logic [1:0] ic, oc;
    logic isg, osg, en;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [31:0] s1_word_reg, s1_word_next;
    logic [54:0] s1_prod_reg, s1_prod_next;
    logic        s1_sgn_reg, s1_sgn_next;
    logic [7:0]  s1_exp_reg, s1_exp_next;
    logic        s1_nan_reg, s1_nan_next, s1_inf_reg, s1_inf_next;
    logic        s1_zero_reg, s1_zero_next;

    logic [31:0] s2_word_reg, s2_word_next;
    logic        s2_neg_reg, s2_neg_next;
    logic [4:0]  s2_lz_reg, s2_lz_next;
    logic [24:0] s2_q_reg, s2_q_next;
    logic signed [9:0] s2_e2_reg, s2_e2_next;
    logic        s2_nan_reg, s2_inf_reg, s2_zero_reg;

    logic [31:0] s3_word_reg, s3_word_next;
    logic        s3_clip_reg, s3_clip_next;

    logic [31:0] sample_out_reg, sample_out_next;
    logic        clipped_reg;

    assign ic = in_float_reg ? 2'd3 : bytes_code(in_bytes_reg);
    assign oc = out_float_reg ? 2'd3 : bytes_code(out_bytes_reg);
    assign isg = in_float_reg | in_signed_reg;
    assign osg = out_float_reg | out_signed_reg;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped   = clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bytes_reg       <= 3'd2;
            in_signed_reg      <= 1'b1;
            in_big_endian_reg  <= 1'b0;
            in_float_reg       <= 1'b0;
            out_bytes_reg      <= 3'd2;
            out_signed_reg     <= 1'b1;
            out_big_endian_reg <= 1'b0;
            out_float_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IN_BYTES:       in_bytes_reg       <= cfg_data;
                REG_IN_SIGNED:      in_signed_reg      <= cfg_data[0];
                REG_IN_BIG_ENDIAN:  in_big_endian_reg  <= cfg_data[0];
                REG_IN_FLOAT:       in_float_reg       <= cfg_data[0];
                REG_OUT_BYTES:      out_bytes_reg      <= cfg_data;
                REG_OUT_SIGNED:     out_signed_reg     <= cfg_data[0];
                REG_OUT_BIG_ENDIAN: out_big_endian_reg <= cfg_data[0];
                REG_OUT_FLOAT:      out_float_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: native order, justify, unpack and scale
    always_comb
    begin
        logic [31:0] v, j;
        logic [23:0] m;
        logic [30:0] scale;
        v = sample_in & byte_mask(ic);
        if (in_big_endian_reg)
        begin
            v = rev_bytes(v, ic);
        end
        j = v;
        if (isg != osg)
        begin
            j = j ^ sign_bit(ic);
        end
        j = j << {~ic, 3'b000};
        m = {|v[30:23], v[22:0]};
        case (oc)
            2'd0:    scale = 31'd127;
            2'd1:    scale = 31'd32767;
            default: scale = 31'h7FFF_FFFF;
        endcase
        s1_word_next = in_float_reg ? v : j;
        s1_prod_next = 55'(m) * 55'(scale);
        s1_sgn_next  = v[31];
        s1_exp_next  = v[30:23];
        s1_nan_next  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        s1_inf_next  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
        s1_zero_next = (v[30:23] == 8'h00);
    end

    // stage 2: product to single precision, leading zeros of integer magnitude
    always_comb
    begin
        logic [4:0]  dc;
        logic [86:0] sh;
        logic [24:0] kept;
        logic        rnd;
        logic [31:0] mag;
        case (oc)
            2'd0:    dc = s1_prod_reg[30] ? 5'd7 : 5'd6;
            2'd1:    dc = s1_prod_reg[38] ? 5'd15 : 5'd14;
            default: dc = s1_prod_reg[54] ? 5'd31 : 5'd30;
        endcase
        sh   = {s1_prod_reg, 32'd0} >> dc;
        kept = sh[56:32];
        rnd  = sh[31] && ((|sh[30:0]) || kept[0]);
        s2_q_next  = kept + 25'(rnd);
        s2_e2_next = $signed({5'd0, dc}) + $signed({2'd0, s1_exp_reg})
                   - $signed({2'd0, EXP_BIAS_INT});
        mag = s1_word_reg[31] ? (~s1_word_reg + 32'd1) : s1_word_reg;
        s2_lz_next   = lzc32(mag);
        s2_word_next = (!in_float_reg && out_float_reg) ? mag : s1_word_reg;
        s2_neg_next  = in_float_reg ? s1_sgn_reg : s1_word_reg[31];
    end

    // stage 3: round to integer and saturate, or normalize and pack, or pass the word through
    always_comb
    begin
        logic [33:0] limit, magn;
        logic [9:0]  nsh;
        logic [4:0]  sh5;
        logic [50:0] tmp;
        logic [31:0] t, n;
        logic [24:0] mr;
        logic [7:0]  ex;
        logic        clip, carry;
        limit = 34'd0;
        magn  = 34'd0;
        nsh   = 10'd0;
        sh5   = 5'd0;
        tmp   = 51'd0;
        t     = 32'd0;
        n     = 32'd0;
        mr    = 25'd0;
        ex    = 8'd0;
        clip  = 1'b0;
        carry = 1'b0;
        if (in_float_reg && out_float_reg)
        begin
            t = s2_word_reg;
        end
        else if (in_float_reg)
        begin
            case (oc)
                2'd0:    limit = 34'd127;
                2'd1:    limit = 34'd32767;
                default: limit = 34'h7FFF_FFFF;
            endcase
            limit = limit + 34'(s2_neg_reg);
            if (s2_nan_reg)
            begin
                clip = 1'b1;
            end
            else if (s2_inf_reg || (!s2_zero_reg && s2_e2_reg > 10'sd9))
            begin
                magn = limit;
                clip = 1'b1;
            end
            else if (s2_zero_reg)
            begin
                magn = 34'd0;
            end
            else if (!s2_e2_reg[9])
            begin
                magn = {9'd0, s2_q_reg} << s2_e2_reg[3:0];
            end
            else
            begin
                nsh  = -s2_e2_reg;
                sh5  = (nsh > 10'd26) ? 5'd26 : nsh[4:0];
                tmp  = {s2_q_reg, 26'd0} >> sh5;
                magn = 34'(tmp[50:26])
                     + 34'(tmp[25] && ((|tmp[24:0]) || tmp[26]));
            end
            if (magn > limit)
            begin
                magn = limit;
                clip = 1'b1;
            end
            t = s2_neg_reg ? (~magn[31:0] + 32'd1) : magn[31:0];
            if (oc == 2'd2)
            begin
                t = t >> 8;
            end
            t = t & byte_mask(oc);
            if (!osg)
            begin
                t = t ^ sign_bit(oc);
            end
        end
        else if (out_float_reg)
        begin
            n     = s2_word_reg << s2_lz_reg;
            mr    = {1'b0, n[31:8]} + 25'(n[7] && ((|n[6:0]) || n[8]));
            carry = mr[24];
            ex    = 8'd127 - {3'd0, s2_lz_reg} + {7'd0, carry};
            if (s2_word_reg != 32'd0)
            begin
                t = {s2_neg_reg, ex, carry ? 23'd0 : mr[22:0]};
            end
        end
        else
        begin
            t = s2_word_reg >> {~oc, 3'b000};
        end
        s3_word_next = t;
        s3_clip_next = clip;
    end

    always_comb
    begin
        sample_out_next = out_big_endian_reg ? rev_bytes(s3_word_reg, oc) : s3_word_reg;
        sample_out_next = sample_out_next & byte_mask(oc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_word_reg    <= s1_word_next;
            s1_prod_reg    <= s1_prod_next;
            s1_sgn_reg     <= s1_sgn_next;
            s1_exp_reg     <= s1_exp_next;
            s1_nan_reg     <= s1_nan_next;
            s1_inf_reg     <= s1_inf_next;
            s1_zero_reg    <= s1_zero_next;
            s2_word_reg    <= s2_word_next;
            s2_neg_reg     <= s2_neg_next;
            s2_lz_reg      <= s2_lz_next;
            s2_q_reg       <= s2_q_next;
            s2_e2_reg      <= s2_e2_next;
            s2_nan_reg     <= s1_nan_reg;
            s2_inf_reg     <= s1_inf_reg;
            s2_zero_reg    <= s1_zero_reg;
            s3_word_reg    <= s3_word_next;
            s3_clip_reg    <= s3_clip_next;
            sample_out_reg <= sample_out_next;
            clipped_reg    <= s3_clip_reg;
        end
    end

    a_clip_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> in_float_reg && !out_float_reg)
        else $error("clipped set outside the float to integer path");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled with the output register free");

    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oc == 2'd0 |-> sample_out[31:8] == 24'd0)
        else $error("unused output bytes not zero");

endmodule
